[design/srl_pkg.sv]
package srl_pkg;

   // Field widths
   localparam int SECONDS_W = 32;
   localparam int MICROS_W  = 20;
   localparam int LENGTH_W  = 18;
   localparam int COUNT_W   = 32;
   localparam int RATE_W    = 16;
   localparam int STAMP_W   = 52;
   localparam int DEADLINE_W = STAMP_W + 1;

   // Fixed constants
   localparam logic [MICROS_W-1:0] MICROS_PER_SECOND = MICROS_W'(1000000);
   localparam logic [16:0]         BYTES_PER_MBIT    = 17'd125000;
   localparam logic [COUNT_W-1:0]  LIMIT_RESET       = COUNT_W'(100 * 125000);

   typedef struct packed {
      logic [SECONDS_W-1:0] time_seconds;
      logic [MICROS_W-1:0]  time_micros;
      logic [LENGTH_W-1:0]  packet_length;
   } req_type;

   typedef struct packed {
      logic               passed;
      logic               log_full_drop;
      logic [COUNT_W-1:0] window_bytes;
      logic [COUNT_W-1:0] total_count;
      logic [COUNT_W-1:0] passed_count;
      logic [COUNT_W-1:0] skipped_count;
      logic [COUNT_W-1:0] peak_window_bytes;
   } rsp_type;

   // One log entry: stamp plus one second, and the packet length
   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [LENGTH_W-1:0]   bytes;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic retire;
      logic decide;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic retire_hit;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RETIRE = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

endpackage

[design/sliding_log_rate_limiter.sv]
// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_stall  req_payload (stamp, length)
// rsp       out        rsp_valid/rsp_stall  rsp_payload (decision, counters)
// csr       in         csr_valid/csr_ready  csr_data (rate_limit_mbps)
//
// A packet is taken, then retires the log entries that are due, then is decided:
// the head of the log memory is read once per cycle, so one entry retires
// per cycle before the decision cycle. The next packet is taken in the
// decision cycle. Reset is synchronous; the log memory is not cleared and
// needs no clearing pass. The result register holds while rsp_stall is high,
// and the decision waits until that register is free.
module sliding_log_rate_limiter #(
   parameter int LOG_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  srl_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output srl_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srl_pkg::RATE_W-1:0]    csr_data
);

   srl_pkg::cmd_type    cmd;
   srl_pkg::status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   srl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srl_datapath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/srl_ctrl.sv]
module srl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  srl_pkg::status_type  status,
   output srl_pkg::cmd_type     cmd
);

   srl_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Result register may be overwritten when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence one packet: take, retire old entries, decide
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_stall = 1'b1;
      case (state_ff)
         srl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = srl_pkg::ST_RETIRE;
            end
         end
         srl_pkg::ST_RETIRE: begin
            if (status.retire_hit) begin
               cmd.retire = 1'b1;
            end else begin
               state_in = srl_pkg::ST_DECIDE;
            end
         end
         srl_pkg::ST_DECIDE: begin
            if (out_free) begin
               cmd.decide = 1'b1;
               req_stall  = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = srl_pkg::ST_RETIRE;
               end else begin
                  state_in = srl_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srl_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/srl_datapath.sv]
module srl_datapath #(
   parameter int LOG_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srl_pkg::req_type                    req_payload,
   input  logic                                csr_write,
   input  logic [srl_pkg::RATE_W-1:0]          csr_data,
   input  srl_pkg::cmd_type                    cmd,
   output srl_pkg::status_type                 status,
   output srl_pkg::rsp_type                    rsp_payload
);

   localparam int ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int FILL_W = $clog2(LOG_DEPTH + 1);
   localparam int TAIL_W = FILL_W + 1;
   localparam int CW     = srl_pkg::COUNT_W;

   srl_pkg::entry_type log_mem [LOG_DEPTH];

   logic [srl_pkg::STAMP_W-1:0]  now_ff;
   logic [srl_pkg::LENGTH_W-1:0] len_ff;
   logic [CW-1:0]                limit_ff;
   logic [ADDR_W-1:0]            head_ff, head_in, head_step;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [CW-1:0]                window_ff, window_in;
   logic [CW-1:0]                total_ff, passed_ff, skipped_ff, peak_ff;
   srl_pkg::entry_type           rd_entry_ff;
   srl_pkg::rsp_type             rsp_ff;

   logic [TAIL_W-1:0]            tail_wide;
   logic [ADDR_W-1:0]            tail_addr;
   logic [CW:0]                  sum_wide;
   logic                         rate_ok, log_full, pass, full_drop;
   logic [CW-1:0]                window_dec, peak_dec;
   logic [CW-1:0]                total_next, passed_next, skipped_next;
   logic [CW:0]                  limit_prod;
   logic                         wr_en;
   srl_pkg::entry_type           wr_entry;

   // Ring pointers
   assign head_step = (head_ff == ADDR_W'(LOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_in   = cmd.retire ? head_step : head_ff;
   assign tail_wide = TAIL_W'(head_ff) + TAIL_W'(fill_ff);
   assign tail_addr = (tail_wide >= TAIL_W'(LOG_DEPTH))
                      ? ADDR_W'(tail_wide - TAIL_W'(LOG_DEPTH))
                      : ADDR_W'(tail_wide);

   // Oldest entry is due when the new stamp reaches its deadline
   assign status.retire_hit = (fill_ff != '0) &&
                              ({1'b0, now_ff} >= rd_entry_ff.deadline);

   // Rate test and log room
   assign sum_wide   = {1'b0, window_ff} + (CW + 1)'(len_ff);
   assign rate_ok    = sum_wide < {1'b0, limit_ff};
   assign log_full   = (fill_ff == FILL_W'(LOG_DEPTH));
   assign pass       = rate_ok && !log_full;
   assign full_drop  = rate_ok && log_full;
   assign window_dec = pass ? window_ff + CW'(len_ff) : window_ff;
   assign peak_dec   = (peak_ff < window_dec) ? window_dec : peak_ff;
   assign total_next   = total_ff + 1'b1;
   assign passed_next  = pass ? passed_ff + 1'b1 : passed_ff;
   assign skipped_next = pass ? skipped_ff : skipped_ff + 1'b1;

   // Byte limit from the rate register, saturated to 32 bits
   assign limit_prod = (CW + 1)'(csr_data) * (CW + 1)'(srl_pkg::BYTES_PER_MBIT);

   // Append a passed packet at the tail
   assign wr_en             = cmd.decide && pass;
   assign wr_entry.deadline = srl_pkg::DEADLINE_W'(now_ff)
                              + srl_pkg::DEADLINE_W'(srl_pkg::MICROS_PER_SECOND);
   assign wr_entry.bytes    = len_ff;

   // Window sum and fill: retire subtracts, a pass adds
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (cmd.retire) begin
         window_in = window_ff - CW'(rd_entry_ff.bytes);
         fill_in   = fill_ff - 1'b1;
      end else if (cmd.decide) begin
         window_in = window_dec;
         if (pass) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Log memory: write the tail, keep reading the next head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         log_mem[tail_addr] <= wr_entry;
      end
      if (wr_en && (tail_addr == head_in)) begin
         rd_entry_ff <= wr_entry;
      end else begin
         rd_entry_ff <= log_mem[head_in];
      end
   end

   // Capture the packet and convert its stamp to microseconds
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= srl_pkg::STAMP_W'(req_payload.time_seconds)
                   * srl_pkg::STAMP_W'(srl_pkg::MICROS_PER_SECOND)
                   + srl_pkg::STAMP_W'(req_payload.time_micros);
         len_ff <= req_payload.packet_length;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_ff.passed            <= pass;
         rsp_ff.log_full_drop     <= full_drop;
         rsp_ff.window_bytes      <= window_dec;
         rsp_ff.total_count       <= total_next;
         rsp_ff.passed_count      <= passed_next;
         rsp_ff.skipped_count     <= skipped_next;
         rsp_ff.peak_window_bytes <= peak_dec;
      end
   end

   // Limiter state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= srl_pkg::LIMIT_RESET;
         head_ff    <= '0;
         fill_ff    <= '0;
         window_ff  <= '0;
         total_ff   <= '0;
         passed_ff  <= '0;
         skipped_ff <= '0;
         peak_ff    <= '0;
      end else begin
         if (csr_write) begin
            limit_ff <= limit_prod[CW] ? '1 : limit_prod[CW-1:0];
         end
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         window_ff <= window_in;
         if (cmd.decide) begin
            total_ff   <= total_next;
            passed_ff  <= passed_next;
            skipped_ff <= skipped_next;
            peak_ff    <= peak_dec;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[design/srl_checker.sv]
module srl_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input srl_pkg::rsp_type  rsp_payload
);

   // Keep a stalled result beat present
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // Keep a stalled result beat unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result beat changed");

   // Every packet is either passed or skipped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.total_count ==
                     rsp_payload.passed_count + rsp_payload.skipped_count))
      else $error("packet counters disagree");

   // A passed packet is never a log-full drop
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.passed |-> !rsp_payload.log_full_drop)
      else $error("passed packet flagged as log-full drop");

   // Peak never falls below the current window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.peak_window_bytes >= rsp_payload.window_bytes)
      else $error("peak below window sum");

endmodule

bind sliding_log_rate_limiter srl_checker u_srl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[tb/sv/testbench.sv]
module testbench;

   localparam int LOG_SLOTS      = 1024;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int END_SETTLE     = 20;
   localparam logic [63:0] US_PER_SEC = 64'd1000000;
   localparam logic [63:0] BYTES_PER_MBPS = 64'd125000;
   localparam logic [63:0] LIMIT_CEILING  = 64'hFFFF_FFFF;

   // One packet held in the one-second window: when it falls out, and its size
   typedef struct packed {
      logic [63:0]                  due;
      logic [srl_pkg::LENGTH_W-1:0] bytes;
   } logged_pkt_type;

   logic                         clock;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   srl_pkg::req_type             req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   srl_pkg::rsp_type             rsp_payload;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [srl_pkg::RATE_W-1:0]   csr_data    = '0;

   // Window predictor state
   logic [srl_pkg::RATE_W-1:0]   rate_mbps   = 16'd100;
   logged_pkt_type               window_log[$];
   logic [srl_pkg::COUNT_W-1:0]  win_bytes   = '0;
   logic [srl_pkg::COUNT_W-1:0]  pkt_total   = '0;
   logic [srl_pkg::COUNT_W-1:0]  pkt_passed  = '0;
   logic [srl_pkg::COUNT_W-1:0]  pkt_dropped = '0;
   logic [srl_pkg::COUNT_W-1:0]  win_peak    = '0;
   int                           full_drops  = 0;

   srl_pkg::req_type             pending_packets[$];
   srl_pkg::rsp_type             expected_verdicts[$];
   logic [63:0]                  stream_us = '0;
   int                           send_idle_pct = 0;
   int                           recv_idle_pct = 0;
   int                           rate_writes   = 0;
   int                           sent_count    = 0;
   int                           mismatch_count = 0;
   logic                         hold_armed = 1'b0;
   logic                         hold_done  = 1'b0;
   int                           hold_left  = 0;
   int                           quiet_cycles = 0;

   sliding_log_rate_limiter #(
      .LOG_DEPTH(LOG_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Append one packet to the pending list
   function automatic void queue_packet(srl_pkg::req_type pkt);
      pending_packets.insert(pending_packets.size(), pkt);
   endfunction

   // Retire stale packets, apply the rate test and log the packet if it passes
   function automatic srl_pkg::rsp_type decide_packet(srl_pkg::req_type pkt);
      logic [63:0]      now_us;
      logic [63:0]      byte_limit;
      logic             rate_ok;
      logic             log_full;
      logged_pkt_type   slot;
      srl_pkg::rsp_type verdict;
      now_us = 64'(pkt.time_seconds) * US_PER_SEC + 64'(pkt.time_micros);
      pkt_total = pkt_total + 32'd1;
      while (window_log.size() != 0 && now_us >= window_log[0].due) begin
         win_bytes = win_bytes - 32'(window_log[0].bytes);
         window_log.delete(0);
      end
      byte_limit = 64'(rate_mbps) * BYTES_PER_MBPS;
      if (byte_limit > LIMIT_CEILING) byte_limit = LIMIT_CEILING;
      rate_ok  = (64'(win_bytes) + 64'(pkt.packet_length)) < byte_limit;
      log_full = rate_ok && (window_log.size() >= LOG_SLOTS);
      if (rate_ok && !log_full) begin
         slot.due   = now_us + US_PER_SEC;
         slot.bytes = pkt.packet_length;
         window_log.insert(window_log.size(), slot);
         win_bytes  = win_bytes + 32'(pkt.packet_length);
         pkt_passed = pkt_passed + 32'd1;
      end else begin
         pkt_dropped = pkt_dropped + 32'd1;
      end
      if (log_full) full_drops++;
      if (win_peak < win_bytes) win_peak = win_bytes;
      verdict.passed            = rate_ok && !log_full;
      verdict.log_full_drop     = log_full;
      verdict.window_bytes      = win_bytes;
      verdict.total_count       = pkt_total;
      verdict.passed_count      = pkt_passed;
      verdict.skipped_count     = pkt_dropped;
      verdict.peak_window_bytes = win_peak;
      return verdict;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_verdict(srl_pkg::rsp_type got);
      srl_pkg::rsp_type want;
      if (expected_verdicts.size() == 0) begin
         $error("result beat with no packet outstanding");
         mismatch_count++;
         return;
      end
      want = expected_verdicts.pop_front();
      compare_field("passed", 32'(want.passed), 32'(got.passed));
      compare_field("log_full_drop", 32'(want.log_full_drop), 32'(got.log_full_drop));
      compare_field("window_bytes", want.window_bytes, got.window_bytes);
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("passed_count", want.passed_count, got.passed_count);
      compare_field("skipped_count", want.skipped_count, got.skipped_count);
      compare_field("peak_window_bytes", want.peak_window_bytes, got.peak_window_bytes);
   endfunction

   function automatic srl_pkg::req_type raw_packet(logic [31:0] secs, logic [19:0] us,
                                                   logic [17:0] len);
      srl_pkg::req_type pkt;
      pkt.time_seconds  = secs;
      pkt.time_micros   = us;
      pkt.packet_length = len;
      return pkt;
   endfunction

   function automatic srl_pkg::req_type stamp_packet(logic [63:0] at_us, logic [17:0] len);
      return raw_packet(32'(at_us / US_PER_SEC), 20'(at_us % US_PER_SEC), len);
   endfunction

   // Queue a run of packets along a forward-moving stamp, with some stale
   // stamps thrown in and the odd jump of several seconds
   task automatic add_stream(int count, int gap_max, int noise_pct, int jump_pct);
      int          roll;
      logic [17:0] len;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if ($urandom_range(3) == 0) len = 18'($urandom_range(1500));
         else len = 18'($urandom_range(262143));
         if (roll < noise_pct) begin
            queue_packet(raw_packet(
               32'($urandom_range(32'(stream_us / US_PER_SEC))),
               20'($urandom_range(20'hFFFFF)), len));
         end else begin
            if (roll < noise_pct + jump_pct)
               stream_us = stream_us + 64'($urandom_range(5000000, 1000000));
            else
               stream_us = stream_us + 64'($urandom_range(gap_max));
            queue_packet(stamp_packet(stream_us, len));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_packets.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_rate(logic [srl_pkg::RATE_W-1:0] mbps);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mbps;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      rate_mbps = mbps;
      rate_writes++;
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
   endtask

   // Driver: offer the next packet, hold it until the block takes the beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_verdicts.insert(expected_verdicts.size(), decide_packet(req_payload));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_packets.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat, stall at random, and once hold off long
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_verdict(rsp_payload);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: give up once no channel has moved a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_idling(31, 74);

      // Reset rate: zero and full lengths, exact one-second retirement,
      // stamps going backwards, one microsecond short, oversized micros
      queue_packet(raw_packet(32'd0, 20'd0, 18'd0));
      queue_packet(raw_packet(32'd0, 20'd0, 18'h3FFFF));
      queue_packet(raw_packet(32'd0, 20'd999999, 18'h3FFFF));
      queue_packet(raw_packet(32'd1, 20'd0, 18'd1));
      queue_packet(raw_packet(32'd0, 20'd500000, 18'd5));
      queue_packet(raw_packet(32'd1, 20'd999998, 18'd7));
      queue_packet(raw_packet(32'd1, 20'd999999, 18'd9));
      queue_packet(raw_packet(32'd2, 20'hFFFFF, 18'd3));
      wait_drained();

      // Zero rate drops everything; the largest stamps empty the log
      write_rate(16'd0);
      queue_packet(raw_packet(32'd5, 20'd0, 18'd0));
      queue_packet(raw_packet(32'hFFFF_FFFF, 20'd999999, 18'h3FFFF));
      queue_packet(raw_packet(32'hFFFF_FFFF, 20'hFFFFF, 18'd0));
      wait_drained();

      // Lowest non-zero rate: land on the byte limit exactly and one under
      write_rate(16'd1);
      queue_packet(raw_packet(32'd10, 20'd0, 18'd100000));
      queue_packet(raw_packet(32'd10, 20'd0, 18'd24999));
      queue_packet(raw_packet(32'd10, 20'd0, 18'd1));
      queue_packet(raw_packet(32'd10, 20'd0, 18'd0));
      queue_packet(raw_packet(32'd10, 20'd999999, 18'd1));
      queue_packet(raw_packet(32'd11, 20'd0, 18'd124999));
      queue_packet(raw_packet(32'd11, 20'd1, 18'd1));
      wait_drained();

      // Moderate rate, mixed pass and drop
      write_rate(16'($urandom_range(40, 5)));
      stream_us = 64'd20 * US_PER_SEC;
      add_stream(400, 250000, 8, 3);
      wait_drained();

      // Saturated limit: fill the log within one second, then retire it
      // all at once; the receiver holds off meanwhile
      write_rate(16'hFFFF);
      set_idling(74, 31);
      stream_us = stream_us + 64'd2 * US_PER_SEC;
      hold_armed <= 1'b1;
      add_stream(1060, 800, 0, 0);
      stream_us = stream_us + 64'd2 * US_PER_SEC;
      queue_packet(stamp_packet(stream_us, 18'h3FFFF));
      add_stream(60, 300000, 5, 3);
      wait_drained();

      // Back to back, low rate
      set_idling(0, 0);
      write_rate(16'($urandom_range(12, 1)));
      add_stream(220, 250000, 8, 3);
      wait_drained();

      // Highest rate that still fits in 32 bits
      write_rate(16'd34359);
      add_stream(10, 100000, 0, 0);
      wait_drained();

      // Accept packets at the very top of the stamp range
      write_rate(16'hFFFF);
      queue_packet(raw_packet(32'hFFFF_FFFF, 20'd999998, 18'h3FFFF));
      queue_packet(raw_packet(32'hFFFF_FFFF, 20'd999999, 18'd0));
      queue_packet(raw_packet(32'hFFFF_FFFF, 20'hFFFFF, 18'h3FFFF));
      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      $display("Sent %0d packets over %0d rate settings: %0d passed, %0d dropped,",
               sent_count, rate_writes, pkt_passed, pkt_dropped);
      $display("%0d on a full log; peak window %0d bytes, %0d mismatching fields or stray beats.",
               full_drops, win_peak, mismatch_count);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
design/srl_pkg.sv
design/srl_ctrl.sv
design/srl_datapath.sv
design/sliding_log_rate_limiter.sv
design/srl_checker.sv
tb/sv/testbench.sv
